// File: rtl/wbs_pkg.sv
`default_nettype none
package wbs_pkg;

    localparam int ANGLE_ITERATIONS_DEF = 24;
    localparam int FRAC_BITS   = 24;
    localparam int SQRT_STEPS  = 30;
    localparam int SUM_W       = 60;
    localparam int CW          = 34;
    localparam int ZW          = 33;
    localparam int NORM_W      = 31;

    localparam logic [1:0] CMD_STOP    = 2'd0;
    localparam logic [1:0] CMD_FORWARD = 2'd1;
    localparam logic [1:0] CMD_CW      = 2'd2;
    localparam logic [1:0] CMD_CCW     = 2'd3;

    localparam logic [1:0] REG_RADIUS   = 2'd0;
    localparam logic [1:0] REG_DEADBAND = 2'd1;

    localparam logic [28:0] RANGE_MAX = 29'h1FFF_FFFF;

    typedef struct packed {
        logic [SUM_W-1:0]    n;
        logic [SUM_W-1:0]    r;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                a_zero;
        logic                b_zero;
        logic                lat_pos;
        logic                lon_pos;
        logic [8:0]          heading;
    } wbs_pipe_t;

    function automatic logic signed [ZW-1:0] atan_val(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 33'sd754974720;
            1:  v = 33'sd445687602;
            2:  v = 33'sd235489088;
            3:  v = 33'sd119537938;
            4:  v = 33'sd60000934;
            5:  v = 33'sd30029717;
            6:  v = 33'sd15018523;
            7:  v = 33'sd7509720;
            8:  v = 33'sd3754917;
            9:  v = 33'sd1877466;
            10: v = 33'sd938734;
            11: v = 33'sd469367;
            12: v = 33'sd234684;
            13: v = 33'sd117342;
            14: v = 33'sd58671;
            15: v = 33'sd29335;
            16: v = 33'sd14668;
            17: v = 33'sd7334;
            18: v = 33'sd3667;
            19: v = 33'sd1833;
            20: v = 33'sd917;
            21: v = 33'sd458;
            22: v = 33'sd229;
            23: v = 33'sd115;
            24: v = 33'sd57;
            25: v = 33'sd29;
            26: v = 33'sd14;
            27: v = 33'sd7;
            28: v = 33'sd4;
            29: v = 33'sd2;
            30: v = 33'sd1;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/wbs_front.sv
`default_nettype none
module wbs_front
    import wbs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire logic               valid_in,
    input  wire logic signed [27:0] target_lat,
    input  wire logic signed [28:0] target_lon,
    input  wire logic signed [27:0] car_lat,
    input  wire logic signed [28:0] car_lon,
    input  wire logic [8:0]         heading_deg,
    output logic                    valid_out,
    output wbs_pipe_t               data_out
);

    // stage A: differences and magnitudes
    logic               va_reg;
    logic [28:0]        a_reg;
    logic [29:0]        b_reg;
    logic               latp_reg, lonp_reg;
    logic [8:0]         hd_reg;
    logic signed [28:0] dlat;
    logic signed [29:0] dlon;

    assign dlat = 29'(target_lat) - 29'(car_lat);
    assign dlon = 30'(target_lon) - 30'(car_lon);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= valid_in;
        end
        if (adv) begin
            a_reg    <= dlat[28] ? 29'(-dlat) : 29'(dlat);
            b_reg    <= dlon[29] ? 30'(-dlon) : 30'(dlon);
            latp_reg <= !dlat[28] && (dlat != '0);
            lonp_reg <= !dlon[29] && (dlon != '0);
            hd_reg   <= (heading_deg >= 9'd360) ? heading_deg - 9'd360 : heading_deg;
        end
    end

    // stage B: squares and normalisation
    logic              vb_reg;
    logic [57:0]       sqa_reg, sqb_reg;
    logic [NORM_W-1:0] an_reg, bn_reg;
    logic              az_reg, bz_reg, latp_b_reg, lonp_b_reg;
    logic [8:0]        hd_b_reg;
    logic [29:0]       ab_or;
    logic [4:0]        msb;
    logic [4:0]        sh;

    assign ab_or = {1'b0, a_reg} | b_reg;

    always_comb begin
        msb = '0;
        for (int i = 0; i < 30; i++) begin
            if (ab_or[i]) msb = 5'(i);
        end
        sh = (ab_or == '0) ? 5'd0 : 5'd30 - msb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (adv) begin
            vb_reg <= va_reg;
        end
        if (adv) begin
            sqa_reg    <= 58'(a_reg) * 58'(a_reg);
            sqb_reg    <= 58'(b_reg) * 58'(b_reg);
            an_reg     <= NORM_W'(a_reg) << sh;
            bn_reg     <= NORM_W'(b_reg) << sh;
            az_reg     <= (a_reg == '0);
            bz_reg     <= (b_reg == '0);
            latp_b_reg <= latp_reg;
            lonp_b_reg <= lonp_reg;
            hd_b_reg   <= hd_reg;
        end
    end

    // stage C: sum of squares, rotator start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out <= 1'b0;
        end else if (adv) begin
            valid_out <= vb_reg;
        end
        if (adv) begin
            data_out.n       <= SUM_W'(sqa_reg) + SUM_W'(sqb_reg);
            data_out.r       <= '0;
            data_out.x       <= CW'(an_reg);
            data_out.y       <= CW'(bn_reg);
            data_out.z       <= '0;
            data_out.a_zero  <= az_reg;
            data_out.b_zero  <= bz_reg;
            data_out.lat_pos <= latp_b_reg;
            data_out.lon_pos <= lonp_b_reg;
            data_out.heading <= hd_b_reg;
        end
    end

endmodule
`default_nettype wire

// File: rtl/wbs_step.sv
`default_nettype none
module wbs_step
    import wbs_pkg::*;
#(
    parameter int STEP             = 0,
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      adv,
    input  wire logic      valid_in,
    input  wbs_pipe_t      data_in,
    output logic           valid_out,
    output wbs_pipe_t      data_out
);

    localparam bit DO_SQRT   = (STEP < SQRT_STEPS);
    localparam bit DO_CORDIC = (STEP < ANGLE_ITERATIONS);
    localparam int BIT_SH    = DO_SQRT ? (2 * SQRT_STEPS - 2 - 2 * STEP) : 0;
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << BIT_SH;
    localparam logic signed [ZW-1:0] ATAN = atan_val(STEP);

    wbs_pipe_t            nxt;
    logic [SUM_W-1:0]     trial;
    logic signed [CW-1:0] xs, ys;

    always_comb begin
        nxt   = data_in;
        trial = data_in.r + BIT;
        xs    = data_in.x >>> STEP;
        ys    = data_in.y >>> STEP;
        if (DO_SQRT) begin
            if (data_in.n >= trial) begin
                nxt.n = data_in.n - trial;
                nxt.r = (data_in.r >> 1) + BIT;
            end else begin
                nxt.r = data_in.r >> 1;
            end
        end
        if (DO_CORDIC) begin
            if (data_in.y > 0) begin
                nxt.x = data_in.x + ys;
                nxt.y = data_in.y - xs;
                nxt.z = data_in.z + ATAN;
            end else begin
                nxt.x = data_in.x - ys;
                nxt.y = data_in.y + xs;
                nxt.z = data_in.z - ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out <= 1'b0;
        end else if (adv) begin
            valid_out <= valid_in;
        end
        if (adv) begin
            data_out <= nxt;
        end
    end

endmodule
`default_nettype wire

// File: rtl/wbs_back.sv
`default_nettype none
module wbs_back
    import wbs_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   adv,
    input  wire logic   valid_in,
    input  wbs_pipe_t   data_in,
    input  wire logic [15:0] radius,
    input  wire logic [7:0]  deadband,
    output logic        valid_out,
    output logic [1:0]  move_cmd,
    output logic [8:0]  bearing_deg,
    output logic [8:0]  heading_error,
    output logic [28:0] range_udeg
);

    localparam logic [33:0] DEG90  = 34'(90)  << FRAC_BITS;
    localparam logic [33:0] DEG180 = 34'(180) << FRAC_BITS;
    localparam logic [33:0] DEG360 = 34'(360) << FRAC_BITS;

    // stage 1: quadrant fold to bearing
    logic [33:0] th, f;
    logic [9:0]  bw;
    logic [8:0]  brg;

    always_comb begin
        if (data_in.z < 0)                    th = '0;
        else if (34'(data_in.z) > DEG90)      th = DEG90;
        else                                  th = 34'(data_in.z);
        if (data_in.lat_pos && data_in.lon_pos)   f = th;
        else if (!data_in.lat_pos && data_in.lon_pos) f = DEG180 - th;
        else if (!data_in.lat_pos)            f = DEG180 + th;
        else                                  f = DEG360 - th;
        bw = f[33:24];
        if (data_in.a_zero && data_in.b_zero) brg = 9'd0;
        else if (data_in.b_zero)              brg = data_in.lat_pos ? 9'd0 : 9'd180;
        else if (data_in.a_zero)              brg = data_in.lon_pos ? 9'd90 : 9'd270;
        else if (bw >= 10'd360)               brg = 9'(bw - 10'd360);
        else                                  brg = bw[8:0];
    end

    logic        v1_reg;
    logic [8:0]  brg_reg, hd_reg;
    logic [29:0] dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= valid_in;
        end
        if (adv) begin
            brg_reg  <= brg;
            hd_reg   <= data_in.heading;
            dist_reg <= data_in.r[29:0];
        end
    end

    // stage 2: heading error and command
    logic [9:0] t;
    logic [8:0] err;
    logic [1:0] cmd;

    always_comb begin
        t   = 10'(brg_reg) + 10'd360 - 10'(hd_reg);
        err = (t >= 10'd360) ? 9'(t - 10'd360) : t[8:0];
        if (dist_reg < 30'(radius))                        cmd = CMD_STOP;
        else if ((10'(err) >= 10'd360 - 10'(deadband)) ||
                 (10'(err) < 10'(deadband)))               cmd = CMD_FORWARD;
        else if (err >= 9'd180)                            cmd = CMD_CCW;
        else                                               cmd = CMD_CW;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out <= 1'b0;
        end else if (adv) begin
            valid_out <= v1_reg;
        end
        if (adv) begin
            move_cmd      <= cmd;
            bearing_deg   <= brg_reg;
            heading_error <= err;
            range_udeg    <= dist_reg[29] ? RANGE_MAX : dist_reg[28:0];
        end
    end

endmodule
`default_nettype wire

// File: rtl/waypoint_bearing_steer_core.sv
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Depth set by the larger of the 30 square root steps and the rotator steps, at most one of each per stage.
// Reset (synchronous, aresetn low): all valid bits cleared, radius 50, deadband 15.
`default_nettype none
module waypoint_bearing_steer_core
    import wbs_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [27:0] s_target_lat,
    input  wire logic signed [28:0] s_target_lon,
    input  wire logic signed [27:0] s_car_lat,
    input  wire logic signed [28:0] s_car_lon,
    input  wire logic [8:0]         s_heading_deg,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_move_cmd,
    output logic [8:0]              m_bearing_deg,
    output logic [8:0]              m_heading_error,
    output logic [28:0]             m_range_udeg
);

    localparam int STEPS = (ANGLE_ITERATIONS > SQRT_STEPS) ? ANGLE_ITERATIONS : SQRT_STEPS;

    logic        adv;
    logic [15:0] radius_reg;
    logic [7:0]  deadband_reg;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= 16'd50;
            deadband_reg <= 8'd15;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RADIUS:   radius_reg   <= cfg_wdata;
                REG_DEADBAND: deadband_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    logic      v [STEPS+1];
    wbs_pipe_t d [STEPS+1];

    wbs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .valid_in    (s_valid && s_ready),
        .target_lat  (s_target_lat),
        .target_lon  (s_target_lon),
        .car_lat     (s_car_lat),
        .car_lon     (s_car_lon),
        .heading_deg (s_heading_deg),
        .valid_out   (v[0]),
        .data_out    (d[0])
    );

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        wbs_step #(
            .STEP             (k),
            .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .valid_in  (v[k]),
            .data_in   (d[k]),
            .valid_out (v[k+1]),
            .data_out  (d[k+1])
        );
    end

    wbs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .valid_in      (v[STEPS]),
        .data_in       (d[STEPS]),
        .radius        (radius_reg),
        .deadband      (deadband_reg),
        .valid_out     (m_valid),
        .move_cmd      (m_move_cmd),
        .bearing_deg   (m_bearing_deg),
        .heading_error (m_heading_error),
        .range_udeg    (m_range_udeg)
    );

endmodule
`default_nettype wire

// File: bench/waypoint_bearing_steer_core_tb.sv
`timescale 1ns / 1ps
module waypoint_bearing_steer_core_tb
    import wbs_pkg::*;
;

    localparam int ITERS      = ANGLE_ITERATIONS_DEF;
    localparam int PIPE_LAT   = 5 + ((ITERS > 30) ? ITERS : 30);
    localparam int CYCLE_CAP  = 600000;
    localparam int HOLD_LEN   = 400;

    localparam longint ATAN_Q24 [32] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [27:0] tlat;
        logic signed [28:0] tlon;
        logic signed [27:0] clat;
        logic signed [28:0] clon;
        logic [8:0]         hdg;
    } fix_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [8:0]  brg;
        logic [8:0]  err;
        logic [28:0] rng;
    } steer_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [27:0] s_target_lat = '0;
    logic signed [28:0] s_target_lon = '0;
    logic signed [27:0] s_car_lat = '0;
    logic signed [28:0] s_car_lon = '0;
    logic [8:0]         s_heading_deg = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_move_cmd;
    logic [8:0]         m_bearing_deg;
    logic [8:0]         m_heading_error;
    logic [28:0]        m_range_udeg;

    waypoint_bearing_steer_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_target_lat(s_target_lat), .s_target_lon(s_target_lon),
        .s_car_lat(s_car_lat), .s_car_lon(s_car_lon), .s_heading_deg(s_heading_deg),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_move_cmd(m_move_cmd), .m_bearing_deg(m_bearing_deg),
        .m_heading_error(m_heading_error), .m_range_udeg(m_range_udeg)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    fix_t   pending_fixes[$];
    steer_t expected_steer[$];
    fix_t   cur_fix;
    logic [15:0] radius_q = 16'd50;
    logic [7:0]  deadband_q = 8'd15;
    bit     calm = 1'b0;
    int     hold_seq = 0;
    int     hold_taken = 0;
    int     hold_cnt = 0;
    int     mismatches = 0;
    int     fixes_sent = 0;
    int     results_seen = 0;
    int     cycles = 0;
    int     n_stop = 0, n_fwd = 0, n_cw = 0, n_ccw = 0;

    function automatic steer_t steer_predict(fix_t f);
        steer_t o;
        longint dlat, dlon, x, y, z, xs, ys, fq;
        longint unsigned a, b, n, r, bt;
        int unsigned brg, hd, err;
        dlat = longint'(f.tlat) - longint'(f.clat);
        dlon = longint'(f.tlon) - longint'(f.clon);
        a = (dlat < 0) ? -dlat : dlat;
        b = (dlon < 0) ? -dlon : dlon;
        n = a * a + b * b;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt = bt >> 2;
        while (bt != 0) begin
            if (n >= r + bt) begin
                n = n - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        if (a == 0 && b == 0) begin
            brg = 0;
        end else if (b == 0) begin
            brg = (dlat > 0) ? 0 : 180;
        end else if (a == 0) begin
            brg = (dlon > 0) ? 90 : 270;
        end else begin
            while ((a | b) < (64'd1 << 30)) begin
                a = a << 1;
                b = b << 1;
            end
            x = a;
            y = b;
            z = 0;
            for (int i = 0; i < ITERS && i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys; y = y - xs; z = z + ATAN_Q24[i];
                end else begin
                    x = x - ys; y = y + xs; z = z - ATAN_Q24[i];
                end
            end
            if (z < 0) z = 0;
            if (z > (longint'(90) << 24)) z = longint'(90) << 24;
            if (dlat > 0 && dlon > 0) fq = z;
            else if (dlat < 0 && dlon > 0) fq = (longint'(180) << 24) - z;
            else if (dlat < 0) fq = (longint'(180) << 24) + z;
            else fq = (longint'(360) << 24) - z;
            brg = int'(fq >>> 24);
            if (brg >= 360) brg = brg - 360;
        end
        hd = f.hdg;
        if (hd >= 360) hd = hd - 360;
        err = (brg + 360 - hd) % 360;
        if (r < radius_q) o.cmd = CMD_STOP;
        else if (err >= 360 - deadband_q || err < deadband_q) o.cmd = CMD_FORWARD;
        else if (err >= 180) o.cmd = CMD_CCW;
        else o.cmd = CMD_CW;
        o.brg = brg[8:0];
        o.err = err[8:0];
        o.rng = (r > RANGE_MAX) ? RANGE_MAX : r[28:0];
        return o;
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_steer.push_back(steer_predict(cur_fix));
                fixes_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_fixes.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
                    cur_fix = pending_fixes.pop_front();
                    s_valid <= 1'b1;
                    s_target_lat <= cur_fix.tlat;
                    s_target_lon <= cur_fix.tlon;
                    s_car_lat <= cur_fix.clat;
                    s_car_lon <= cur_fix.clon;
                    s_heading_deg <= cur_fix.hdg;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        steer_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_steer.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: cmd %0d brg %0d", m_move_cmd,
                                               m_bearing_deg);
            end else begin
                e = expected_steer.pop_front();
                case (e.cmd)
                    CMD_STOP:    n_stop++;
                    CMD_FORWARD: n_fwd++;
                    CMD_CW:      n_cw++;
                    default:     n_ccw++;
                endcase
                if (m_move_cmd !== e.cmd || m_bearing_deg !== e.brg ||
                    m_heading_error !== e.err || m_range_udeg !== e.rng) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp cmd %0d brg %0d err %0d rng %0d, got %0d %0d %0d %0d",
                                 e.cmd, e.brg, e.err, e.rng, m_move_cmd, m_bearing_deg,
                                 m_heading_error, m_range_udeg);
                end
            end
        end
        if (hold_seq != hold_taken) begin
            hold_taken <= hold_seq;
            hold_cnt <= HOLD_LEN;
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && (calm || $urandom_range(99) >= 17);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("waypoint_bearing_steer_core_tb: FAIL");
            $finish;
        end
    end

    task automatic add_fix(int tlat, int tlon, int clat, int clon, int hdg);
        fix_t f;
        f.tlat = tlat[27:0];
        f.tlon = tlon[28:0];
        f.clat = clat[27:0];
        f.clon = clon[28:0];
        f.hdg = hdg[8:0];
        pending_fixes.push_back(f);
    endtask

    task automatic add_random_fix();
        int kind, clat, clon, hdg;
        kind = $urandom_range(99);
        hdg = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(359);
        clat = int'($urandom_range(180000000)) - 90000000;
        clon = int'($urandom_range(360000000)) - 180000000;
        if (kind < 65) begin
            add_fix(int'($urandom_range(180000000)) - 90000000,
                    int'($urandom_range(360000000)) - 180000000, clat, clon, hdg);
        end else if (kind < 82) begin
            add_fix(clat + int'($urandom_range(4000)) - 2000,
                    clon + int'($urandom_range(4000)) - 2000, clat, clon, hdg);
        end else if (kind < 90) begin
            if ($urandom_range(1))
                add_fix(clat, int'($urandom_range(360000000)) - 180000000, clat, clon, hdg);
            else
                add_fix(int'($urandom_range(180000000)) - 90000000, clon, clat, clon, hdg);
        end else begin
            add_fix(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                    int'($urandom_range(511)));
        end
    endtask

    // checked after the edge has settled, so a just-popped item is seen as in flight
    task automatic wait_idle();
        while (pending_fixes.size() != 0 || s_valid || expected_steer.size() != 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (PIPE_LAT + 10) @(posedge aclk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_RADIUS) radius_q = val;
        else if (idx == REG_DEADBAND) deadband_q = val[7:0];
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset values, then directed fixes
        add_fix(1000, 2000, 1000, 2000, 0);
        add_fix(5000, 0, 0, 0, 10);
        add_fix(0, 5000, 0, 0, 90);
        add_fix(-5000, 0, 0, 0, 185);
        add_fix(0, -5000, 0, 0, 280);
        add_fix(3000, 3000, 0, 0, 359);
        add_fix(-3000, 3000, 0, 0, 360);
        add_fix(-3000, -3000, 0, 0, 511);
        add_fix(3000, -3000, 0, 0, 400);
        add_fix(90000000, 180000000, -90000000, -180000000, 45);
        add_fix(-134217728, -268435456, 134217727, 268435455, 200);
        add_fix(134217727, 268435455, -134217728, -268435456, 0);
        add_fix(30, 40, 0, 0, 0);
        add_fix(30, 39, 0, 0, 0);
        add_fix(1, 1000000, 0, 0, 75);
        add_fix(1000000, 1, 0, 0, 345);
        add_fix(1000000, 0, 0, 0, 15);
        add_fix(1000000, 0, 0, 0, 16);
        add_fix(1000000, 0, 0, 0, 180);
        add_fix(0, 1000000, 0, 0, 270);
        add_fix(-1, -1, 0, 0, 0);
        add_fix(-90000000, 0, 90000000, 0, 0);
        wait_idle();

        set_reg(REG_RADIUS, 16'd0);
        set_reg(REG_DEADBAND, 16'd0);
        set_reg(2'd2, 16'hFFFF);
        set_reg(2'd3, 16'hFFFF);
        add_fix(0, 0, 0, 0, 0);
        add_fix(1000, 0, 0, 0, 0);
        hold_seq = hold_seq + 1;
        for (int i = 0; i < 240; i++) add_random_fix();
        wait_idle();

        set_reg(REG_RADIUS, 16'd65535);
        set_reg(REG_DEADBAND, 16'd179);
        for (int i = 0; i < 120; i++) add_random_fix();
        wait_idle();
        for (int i = 0; i < 120; i++) add_random_fix();
        wait_idle();

        set_reg(REG_RADIUS, 16'd1000);
        set_reg(REG_DEADBAND, 16'd255);
        calm = 1'b1;
        for (int i = 0; i < 240; i++) add_random_fix();
        wait_idle();
        calm = 1'b0;

        set_reg(REG_RADIUS, 16'd700);
        set_reg(REG_DEADBAND, 16'd180);
        for (int i = 0; i < 120; i++) add_random_fix();
        wait_idle();
        set_reg(REG_DEADBAND, 16'd1);
        for (int i = 0; i < 120; i++) add_random_fix();
        wait_idle();

        set_reg(REG_RADIUS, 16'd50);
        set_reg(REG_DEADBAND, 16'd15);
        hold_seq = hold_seq + 1;
        for (int i = 0; i < 240; i++) add_random_fix();
        wait_idle();

        $display("%0d fixes sent, %0d results; stop %0d forward %0d cw %0d ccw %0d",
                 fixes_sent, results_seen, n_stop, n_fwd, n_cw, n_ccw);
        $display("covered axes, quadrants, saturated range, odd headings, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_steer.size() == 0) begin
            $display("waypoint_bearing_steer_core_tb: PASS");
        end else begin
            $display("waypoint_bearing_steer_core_tb: FAIL");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/wbs_pkg.sv
rtl/wbs_front.sv
rtl/wbs_step.sv
rtl/wbs_back.sv
rtl/waypoint_bearing_steer_core.sv
bench/waypoint_bearing_steer_core_tb.sv
